/* design/gbw_pkg.sv */
// ----------------------------------------------------------------------------
// gbw_pkg
// Shared types and constants of the grind-by-weight dosing controller.
// ----------------------------------------------------------------------------
package gbw_pkg;

  localparam int unsigned DivW = 32;

  // phase codes as seen on the result word
  localparam logic [3:0] PH_IDLE       = 4'd0;
  localparam logic [3:0] PH_FILTER     = 4'd1;
  localparam logic [3:0] PH_PRESSED    = 4'd2;
  localparam logic [3:0] PH_CONFIRM    = 4'd3;
  localparam logic [3:0] PH_TARE       = 4'd4;
  localparam logic [3:0] PH_CONFIGURED = 4'd5;
  localparam logic [3:0] PH_RUN        = 4'd6;
  localparam logic [3:0] PH_TOPUP      = 4'd7;
  localparam logic [3:0] PH_STOP       = 4'd8;
  localparam logic [3:0] PH_FINAL      = 4'd9;
  localparam logic [3:0] PH_DEBUG      = 4'd10;

  localparam logic [1:0] BTN_NONE  = 2'd0;
  localparam logic [1:0] BTN_LEFT  = 2'd1;
  localparam logic [1:0] BTN_RIGHT = 2'd2;
  localparam logic [1:0] BTN_BACK  = 2'd3;

  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_BUTTON = 2'd1;
  localparam logic [1:0] CMD_BACK   = 2'd2;
  localparam logic [1:0] CMD_REMOTE = 2'd3;

  localparam logic [2:0] REG_SINGLE_DOSE   = 3'd0;
  localparam logic [2:0] REG_DOUBLE_DOSE   = 3'd1;
  localparam logic [2:0] REG_SINGLE_MARGIN = 3'd2;
  localparam logic [2:0] REG_DOUBLE_MARGIN = 3'd3;
  localparam logic [2:0] REG_MIN_GAIN      = 3'd4;
  localparam logic [2:0] REG_SETTLE        = 3'd5;

  localparam logic [14:0] RST_SINGLE_DOSE   = 15'd900;
  localparam logic [14:0] RST_DOUBLE_DOSE   = 15'd1800;
  localparam logic [14:0] RST_SINGLE_MARGIN = 15'd100;
  localparam logic [14:0] RST_DOUBLE_MARGIN = 15'd150;
  localparam logic [14:0] RST_MIN_GAIN      = 15'd10;
  localparam logic [15:0] RST_SETTLE        = 16'd1000;

  typedef struct packed {
    logic [1:0]         cmd;
    logic               button_side;
    logic [31:0]        now_ms;
    logic signed [15:0] weight_cg;
    logic               weight_stable;
    logic               tare_ok;
    logic               button_still_low;
    logic [14:0]        request_dose_cg;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         phase;
    logic               relay_on;
    logic signed [15:0] shown_weight_cg;
    logic [14:0]        target_cg;
    logic [31:0]        elapsed_ms;
    logic               topup_report;
    logic [31:0]        last_run_ms;
    logic signed [15:0] topup_gain_cg;
    logic signed [15:0] final_weight_cg;
    logic [31:0]        final_time_ms;
    logic               session_done;
  } out_item_t;

  typedef enum logic [1:0] {
    SEL_RATE = 2'd0,
    SEL_AVG  = 2'd1,
    SEL_TIME = 2'd2
  } div_sel_e;

  typedef struct packed {
    logic     load_item;
    logic     div_start;
    div_sel_e div_sel;
    logic     cap_avg;
    logic     cap_avg10;
    logic     cap_quot;
    logic     commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic run_div;
    logic topup_div;
    logic count_zero;
    logic avg_zero;
  } ctrl_sts_t;

endpackage

/* design/gbw_div.sv */
// ----------------------------------------------------------------------------
// gbw_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gbw_div #(
  parameter int unsigned Width = gbw_pkg::DivW
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [Width-1:0] dividend_i,
  input  logic [Width-1:0] divisor_i,
  output logic             done_o,
  output logic [Width-1:0] quotient_o
);

  localparam int unsigned CntW = $clog2(Width);

  logic             busy_q, done_q;
  logic [CntW-1:0]  cnt_q;
  logic [Width-1:0] rem_q, quo_q, den_q;
  logic [Width:0]   rem_sh;
  logic [Width:0]   rem_sub;

  assign rem_sh  = {rem_q, quo_q[Width-1]};
  assign rem_sub = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(Width - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      den_q <= divisor_i;
    end else if (busy_q) begin
      // divide by zero yields all ones, which callers saturate
      if (!rem_sub[Width]) begin
        rem_q <= rem_sub[Width-1:0];
        quo_q <= {quo_q[Width-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[Width-1:0];
        quo_q <= {quo_q[Width-2:0], 1'b0};
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q && !done_q)
    else $error("divider did not start");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider done while busy");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("divider done held");

endmodule

/* design/gbw_ctrl.sv */
// ----------------------------------------------------------------------------
// gbw_ctrl
// Sequencer: takes a word, runs the divisions it needs, hands off the result.
// ----------------------------------------------------------------------------
module gbw_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  logic              div_done_i,
  input  gbw_pkg::ctrl_sts_t sts_i,
  output gbw_pkg::ctrl_cmd_t cmd_o
);
  import gbw_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_EVAL   = 7'b0000010,
    ST_DIVR   = 7'b0000100,
    ST_DIVA   = 7'b0001000,
    ST_AVGCHK = 7'b0010000,
    ST_DIVT   = 7'b0100000,
    ST_EMIT   = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.div_sel = SEL_RATE;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (sts_i.run_div) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = SEL_RATE;
          state_d = ST_DIVR;
        end else if (sts_i.topup_div) begin
          if (sts_i.count_zero) begin
            cmd_o.cap_avg10 = 1'b1;
            state_d = ST_AVGCHK;
          end else begin
            cmd_o.div_start = 1'b1;
            cmd_o.div_sel   = SEL_AVG;
            state_d = ST_DIVA;
          end
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_DIVR, ST_DIVT: begin
        if (div_done_i) begin
          cmd_o.cap_quot = 1'b1;
          state_d = ST_EMIT;
        end
      end
      ST_DIVA: begin
        if (div_done_i) begin
          cmd_o.cap_avg = 1'b1;
          state_d = ST_AVGCHK;
        end
      end
      ST_AVGCHK: begin
        if (sts_i.avg_zero) begin
          state_d = ST_EMIT;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = SEL_TIME;
          state_d = ST_DIVT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.commit) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  a_accept_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == ST_EVAL)
    else $error("accepted word not evaluated");
  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> !out_valid_q || out_ready_i)
    else $error("result overwritten");
  a_commit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> out_valid_q && in_ready_o)
    else $error("result not presented");

endmodule

/* design/gbw_dp.sv */
// ----------------------------------------------------------------------------
// gbw_dp
// Dosing datapath: session state, config registers, phase update, result word.
// ----------------------------------------------------------------------------
module gbw_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gbw_pkg::in_item_t   in_data_i,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [15:0]         cfg_data_i,
  input  gbw_pkg::ctrl_cmd_t  cmd_i,
  output gbw_pkg::ctrl_sts_t  sts_o,
  output logic [31:0]         div_dividend_o,
  output logic [31:0]         div_divisor_o,
  input  logic [31:0]         div_quotient_i,
  output gbw_pkg::out_item_t  out_data_o
);
  import gbw_pkg::*;

  // configuration
  logic [14:0] single_dose_q, double_dose_q, single_margin_q, double_margin_q;
  logic [14:0] min_gain_q;
  logic [15:0] settle_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      single_dose_q   <= RST_SINGLE_DOSE;
      double_dose_q   <= RST_DOUBLE_DOSE;
      single_margin_q <= RST_SINGLE_MARGIN;
      double_margin_q <= RST_DOUBLE_MARGIN;
      min_gain_q      <= RST_MIN_GAIN;
      settle_q        <= RST_SETTLE;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SINGLE_DOSE:   single_dose_q   <= cfg_data_i[14:0];
        REG_DOUBLE_DOSE:   double_dose_q   <= cfg_data_i[14:0];
        REG_SINGLE_MARGIN: single_margin_q <= cfg_data_i[14:0];
        REG_DOUBLE_MARGIN: double_margin_q <= cfg_data_i[14:0];
        REG_MIN_GAIN:      min_gain_q      <= cfg_data_i[14:0];
        REG_SETTLE:        settle_q        <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // session state
  logic [3:0]         phase_q, phase_d, pbp_q, pbp_d;
  logic [1:0]         pbtn_q, pbtn_d, prevbtn_q, prevbtn_d;
  logic [31:0]        press_time_q, press_time_d, filter_time_q, filter_time_d;
  logic [14:0]        target_q, target_d;
  logic signed [15:0] corr_q, corr_d;
  logic [31:0]        sess_start_q, sess_start_d;
  logic signed [15:0] prev_w_q, prev_w_d;
  logic [31:0]        prev_wt_q, prev_wt_d;
  logic [31:0]        rate_sum_q, rate_sum_d;
  logic [15:0]        rate_cnt_q, rate_cnt_d;
  logic               motor_q, motor_d;
  logic signed [15:0] w_on_q, w_on_d;
  logic [31:0]        on_time_q, on_time_d, run_len_q, run_len_d;
  logic [31:0]        topup_end_q, topup_end_d, stop_time_q, stop_time_d;
  logic [31:0]        settle_start_q, settle_start_d, fstamp_q, fstamp_d;
  logic signed [15:0] fweight_q, fweight_d;
  logic [31:0]        fdur_q, fdur_d;

  in_item_t    item_q;
  logic [15:0] avg_q;
  logic [31:0] quot_q;
  out_item_t   out_q, out_d;

  // item fields
  logic [31:0]        t;
  logic signed [15:0] w;
  assign t = item_q.now_ms;
  assign w = item_q.weight_cg;

  logic               tick;
  logic [31:0]        since_sess;
  logic signed [16:0] run_gain, top_gain, tgt_s, tdiff;
  logic [31:0]        dt;
  logic [25:0]        run_num, time_num;
  logic [35:0]        dt_x10;
  logic               run_over, run_light, run_small, run_past;
  logic               heavy, late, eval_ok, near_target;
  logic [10:0]        ms_clamped;
  logic [15:0]        rq_sat;

  assign tick       = (item_q.cmd == CMD_TICK);
  assign since_sess = t - sess_start_q;
  assign run_gain   = 17'(w) - 17'(prev_w_q);
  assign dt         = t - prev_wt_q;
  assign run_num    = 26'(run_gain[15:0]) * 26'd1000;
  assign dt_x10     = {dt, 3'b000} + {3'b000, dt, 1'b0};
  assign run_over   = since_sess > 32'd30000;
  assign run_light  = w < 16'sd100;
  assign run_small  = run_gain < 17'sd20;
  assign run_past   = prev_w_q > corr_q;

  assign top_gain    = 17'(w) - 17'(w_on_q);
  assign tgt_s       = {2'b00, target_q};
  assign tdiff       = tgt_s - 17'(w);
  assign time_num    = 26'(tdiff[15:0]) * 26'd1000;
  assign heavy       = top_gain >= $signed({2'b00, min_gain_q});
  assign late        = (t - topup_end_q) >= {16'd0, settle_q};
  assign eval_ok     = late || (heavy && item_q.weight_stable);
  assign near_target = 17'(w) >= (tgt_s - 17'sd8);

  assign rq_sat = (|quot_q[31:16]) ? 16'hFFFF : quot_q[15:0];
  assign ms_clamped = (quot_q < 32'd500)  ? 11'd500 :
                      (quot_q > 32'd1300) ? 11'd1300 : quot_q[10:0];

  always_comb begin
    sts_o.run_div   = tick && (phase_q == PH_RUN) && !run_over && !run_light &&
                      !run_small && !run_past;
    sts_o.topup_div = tick && (phase_q == PH_TOPUP) && !motor_q && eval_ok &&
                      !near_target;
    sts_o.count_zero = (rate_cnt_q == 16'd0);
    sts_o.avg_zero   = (avg_q == 16'd0);
  end

  always_comb begin
    case (cmd_i.div_sel)
      SEL_AVG: begin
        div_dividend_o = rate_sum_q;
        div_divisor_o  = {16'd0, rate_cnt_q};
      end
      SEL_TIME: begin
        div_dividend_o = {6'd0, time_num};
        div_divisor_o  = {16'd0, avg_q};
      end
      default: begin
        div_dividend_o = {6'd0, run_num};
        div_divisor_o  = dt;
      end
    endcase
  end

  logic rep, done;
  logic signed [16:0] gain_out;
  logic signed [15:0] shown;

  always_comb begin
    phase_d = phase_q; pbp_d = pbp_q; pbtn_d = pbtn_q; prevbtn_d = prevbtn_q;
    press_time_d = press_time_q; filter_time_d = filter_time_q;
    target_d = target_q; corr_d = corr_q; sess_start_d = sess_start_q;
    prev_w_d = prev_w_q; prev_wt_d = prev_wt_q;
    rate_sum_d = rate_sum_q; rate_cnt_d = rate_cnt_q;
    motor_d = motor_q; w_on_d = w_on_q; on_time_d = on_time_q; run_len_d = run_len_q;
    topup_end_d = topup_end_q; stop_time_d = stop_time_q;
    settle_start_d = settle_start_q; fstamp_d = fstamp_q;
    fweight_d = fweight_q; fdur_d = fdur_q;
    rep = 1'b0; done = 1'b0;

    case (item_q.cmd)
      CMD_BUTTON: begin
        filter_time_d = t;
        if ((t - press_time_q) >= 32'd150) begin
          if (phase_q == PH_CONFIRM) begin
            phase_d = (prevbtn_q == (item_q.button_side ? BTN_RIGHT : BTN_LEFT)) ?
                      PH_TARE : PH_IDLE;
          end else if (phase_q == PH_IDLE) begin
            pbp_d   = PH_IDLE;
            phase_d = PH_FILTER;
            pbtn_d  = item_q.button_side ? BTN_RIGHT : BTN_LEFT;
          end
          prevbtn_d = BTN_NONE;
        end
      end
      CMD_BACK: begin
        if (phase_q != PH_PRESSED) pbp_d = phase_q;
        phase_d = PH_PRESSED;
        pbtn_d  = BTN_BACK;
      end
      CMD_REMOTE: begin
        if (phase_q == PH_IDLE) begin
          target_d = item_q.request_dose_cg;
          corr_d   = (item_q.request_dose_cg > 15'd150) ?
                     $signed({1'b0, item_q.request_dose_cg - 15'd150}) :
                     $signed({1'b0, item_q.request_dose_cg});
          prevbtn_d    = BTN_RIGHT;
          press_time_d = t;
          phase_d      = PH_CONFIRM;
        end
      end
      default: begin
        case (phase_q)
          PH_FILTER: begin
            if ((t - filter_time_q) > 32'd20) phase_d = PH_PRESSED;
            else if (!item_q.button_still_low) phase_d = PH_IDLE;
          end
          PH_PRESSED: begin
            if (pbp_q == PH_DEBUG) begin
              phase_d = (pbtn_q == BTN_LEFT || pbtn_q == BTN_RIGHT) ? PH_DEBUG : PH_IDLE;
            end else if (pbp_q == PH_IDLE) begin
              prevbtn_d    = pbtn_q;
              press_time_d = t;
              case (pbtn_q)
                BTN_LEFT: begin
                  target_d = single_dose_q;
                  corr_d   = 16'({1'b0, single_dose_q}) - 16'({1'b0, single_margin_q});
                  phase_d  = PH_CONFIRM;
                end
                BTN_RIGHT: begin
                  target_d = double_dose_q;
                  corr_d   = 16'({1'b0, double_dose_q}) - 16'({1'b0, double_margin_q});
                  phase_d  = PH_CONFIRM;
                end
                BTN_BACK: phase_d = PH_DEBUG;
                default:  phase_d = PH_IDLE;
              endcase
            end else begin
              phase_d = pbp_q;
            end
          end
          PH_CONFIRM: begin
            if ((t - press_time_q) > 32'd2000) phase_d = PH_IDLE;
          end
          PH_TARE: begin
            if (item_q.tare_ok) phase_d = PH_CONFIGURED;
          end
          PH_CONFIGURED: begin
            w_on_d = w; on_time_d = t; motor_d = 1'b1;
            sess_start_d = t; prev_w_d = w; prev_wt_d = t;
            rate_sum_d = '0; rate_cnt_d = '0;
            phase_d = PH_RUN;
          end
          PH_RUN: begin
            if (run_over) begin
              phase_d = PH_STOP;
            end else if (!run_light && !run_small) begin
              if (run_past) begin
                phase_d = PH_TOPUP;
              end else begin
                prev_w_d  = w;
                prev_wt_d = t;
                if ({10'd0, run_num} > dt_x10 && rate_cnt_q != 16'hFFFF) begin
                  rate_sum_d = rate_sum_q + {16'd0, rq_sat};
                  rate_cnt_d = rate_cnt_q + 16'd1;
                end
              end
            end
          end
          PH_TOPUP: begin
            if (!motor_q) begin
              if (eval_ok) begin
                rep = 1'b1;
                if (near_target || avg_q == 16'd0) begin
                  phase_d = PH_STOP;
                end else begin
                  stop_time_d = t + {21'd0, ms_clamped};
                  w_on_d = w; on_time_d = t; motor_d = 1'b1;
                end
              end
            end else if (t > stop_time_q) begin
              run_len_d   = t - on_time_q;
              motor_d     = 1'b0;
              topup_end_d = t;
            end
          end
          PH_STOP: begin
            if (motor_q) begin
              run_len_d      = t - on_time_q;
              motor_d        = 1'b0;
              settle_start_d = t;
            end else if (item_q.weight_stable || (t - settle_start_q) >= 32'd1500) begin
              fstamp_d  = t;
              fweight_d = w;
              fdur_d    = t - sess_start_q;
              phase_d   = PH_FINAL;
              done      = 1'b1;
            end
          end
          PH_FINAL: begin
            if ((t - fstamp_q) > 32'd8000) phase_d = PH_IDLE;
          end
          default: ;
        endcase
      end
    endcase

    // result word from the updated state
    shown = w;
    if (phase_d == PH_IDLE && w > -16'sd30 && w < 16'sd30) shown = '0;
    if (phase_d == PH_FINAL) shown = fweight_d;
    gain_out = 17'(w) - 17'(w_on_d);

    out_d.phase           = phase_d;
    out_d.relay_on        = motor_d;
    out_d.shown_weight_cg = shown;
    out_d.target_cg       = target_d;
    out_d.elapsed_ms      = t - sess_start_d;
    out_d.topup_report    = rep;
    out_d.last_run_ms     = run_len_d;
    out_d.topup_gain_cg   = (gain_out > 17'sd32767)  ? 16'sh7FFF :
                            (gain_out < -17'sd32768) ? 16'sh8000 : gain_out[15:0];
    out_d.final_weight_cg = fweight_d;
    out_d.final_time_ms   = fdur_d;
    out_d.session_done    = done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE; pbp_q <= PH_IDLE; pbtn_q <= BTN_NONE; prevbtn_q <= BTN_NONE;
      press_time_q <= '0; filter_time_q <= '0; target_q <= '0; corr_q <= '0;
      sess_start_q <= '0; prev_w_q <= '0; prev_wt_q <= '0;
      rate_sum_q <= '0; rate_cnt_q <= '0; motor_q <= 1'b0; w_on_q <= '0;
      on_time_q <= '0; run_len_q <= '0; topup_end_q <= '0; stop_time_q <= '0;
      settle_start_q <= '0; fstamp_q <= '0; fweight_q <= '0; fdur_q <= '0;
    end else if (cmd_i.commit) begin
      phase_q <= phase_d; pbp_q <= pbp_d; pbtn_q <= pbtn_d; prevbtn_q <= prevbtn_d;
      press_time_q <= press_time_d; filter_time_q <= filter_time_d;
      target_q <= target_d; corr_q <= corr_d;
      sess_start_q <= sess_start_d; prev_w_q <= prev_w_d; prev_wt_q <= prev_wt_d;
      rate_sum_q <= rate_sum_d; rate_cnt_q <= rate_cnt_d;
      motor_q <= motor_d; w_on_q <= w_on_d;
      on_time_q <= on_time_d; run_len_q <= run_len_d;
      topup_end_q <= topup_end_d; stop_time_q <= stop_time_d;
      settle_start_q <= settle_start_d; fstamp_q <= fstamp_d;
      fweight_q <= fweight_d; fdur_q <= fdur_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) item_q <= in_data_i;
    if (cmd_i.cap_avg)   avg_q  <= div_quotient_i[15:0];
    if (cmd_i.cap_avg10) avg_q  <= 16'd10;
    if (cmd_i.cap_quot)  quot_q <= div_quotient_i;
    if (cmd_i.commit)    out_q  <= out_d;
  end

  assign out_data_o = out_q;

  // a back press while grinding parks the phase in pressed with the relay on
  a_relay_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    motor_q |-> phase_q == PH_RUN || phase_q == PH_TOPUP || phase_q == PH_STOP ||
                phase_q == PH_PRESSED)
    else $error("relay on outside grinding");
  a_done_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit && done |=> phase_q == PH_FINAL)
    else $error("session done without finalize");
  a_cnt_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rate_cnt_q == 16'd0 |-> rate_sum_q == 32'd0)
    else $error("rate sum without samples");

endmodule

/* design/grind_by_weight_dosing_controller.sv */
// ----------------------------------------------------------------------------
// grind_by_weight_dosing_controller
// Grind-by-weight dosing sequencer: button, remote and tick words in, one
// status word out per input word.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid_i/in_ready_o/in_data_i): one word per event, a tick
//   with a tared weight sample, a button edge or a remote dose request.
//   out channel (out_valid_o/out_ready_i/out_data_o): one status word per
//   input word, in order.
//   cfg port (cfg_we_i/cfg_idx_i/cfg_data_i): dose, margin, gain and settle
//   registers, written while no word is in flight.
// Sequencing: a word without division goes from evaluation straight to its
// result, and the block is ready for the next word in the same cycle as that
// result turns valid; a run tick that measures the flow rate waits on one divide;
// a top-up evaluation takes up to two divides, one for the average rate and one
// for the pulse length. All divides go through the shared radix-2 divider; one
// word is in work at a time.
// Reset: idle phase, relay off, registers at their default values.
// Stall: a result waits in the output register; the next word is accepted
// and worked, then held until the output register is free.
// ----------------------------------------------------------------------------
module grind_by_weight_dosing_controller (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  gbw_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output gbw_pkg::out_item_t out_data_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i
);
  import gbw_pkg::*;

  ctrl_cmd_t   cmd;
  ctrl_sts_t   sts;
  logic        div_done;
  logic [DivW-1:0] div_dividend, div_divisor, div_quotient;

  gbw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .div_done_i  (div_done),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  gbw_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_data_i      (in_data_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .div_dividend_o (div_dividend),
    .div_divisor_o  (div_divisor),
    .div_quotient_i (div_quotient),
    .out_data_o     (out_data_o)
  );

  gbw_div #(.Width(DivW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quotient)
  );

endmodule

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the grind-by-weight dosing controller: directed
// session walks, register sweeps and random event streams against a local
// model of the sequencer, with random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import gbw_pkg::*;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  in_item_t   in_data_i;
  logic       out_valid_o;
  logic       out_ready_i;
  out_item_t  out_data_o;
  logic       cfg_we_i;
  logic [2:0] cfg_idx_i;
  logic [15:0] cfg_data_i;

  grind_by_weight_dosing_controller i_dut (.*);

  // predictor copy of registers and state
  logic [14:0] c_single, c_double, c_smargin, c_dmargin, c_mingain;
  logic [15:0] c_settle;
  logic [3:0]  s_phase, s_before;
  logic [1:0]  s_pressed, s_prevbtn;
  logic [31:0] s_press_t, s_filter_t, s_start, s_prevw_t, s_sum;
  logic [31:0] s_on_t, s_runlen, s_topend, s_stop_t, s_settle_t, s_fstamp, s_fdur;
  int          s_target, s_corr, s_prevw, s_won, s_fweight;
  logic [31:0] s_count;
  logic        s_motor;

  out_item_t   status_q[$];
  int          errors, n_items, n_words, idle_pct, watchdog;
  logic [31:0] clock_ms;
  logic        quiet_out;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic reset_model();
    c_single = RST_SINGLE_DOSE; c_double = RST_DOUBLE_DOSE;
    c_smargin = RST_SINGLE_MARGIN; c_dmargin = RST_DOUBLE_MARGIN;
    c_mingain = RST_MIN_GAIN; c_settle = RST_SETTLE;
    s_phase = PH_IDLE; s_before = PH_IDLE; s_pressed = BTN_NONE; s_prevbtn = BTN_NONE;
    s_press_t = 0; s_filter_t = 0; s_start = 0; s_prevw_t = 0; s_sum = 0; s_count = 0;
    s_on_t = 0; s_runlen = 0; s_topend = 0; s_stop_t = 0; s_settle_t = 0;
    s_fstamp = 0; s_fdur = 0; s_target = 0; s_corr = 0; s_prevw = 0; s_won = 0;
    s_fweight = 0; s_motor = 0;
  endtask

  function automatic out_item_t dose_step(in_item_t it);
    out_item_t   r;
    logic [31:0] t, dt, avg;
    longint      num, rq, ms;
    int          w, g;
    logic [1:0]  b;
    logic        rep, done;
    t = it.now_ms; w = it.weight_cg; rep = 0; done = 0;
    case (it.cmd)
      CMD_BUTTON: begin
        b = it.button_side ? BTN_RIGHT : BTN_LEFT;
        s_filter_t = t;
        if (t - s_press_t >= 32'd150) begin
          if (s_phase == PH_CONFIRM) s_phase = (b == s_prevbtn) ? PH_TARE : PH_IDLE;
          else if (s_phase == PH_IDLE) begin
            s_before = PH_IDLE; s_phase = PH_FILTER; s_pressed = b;
          end
          s_prevbtn = BTN_NONE;
        end
      end
      CMD_BACK: begin
        if (s_phase != PH_PRESSED) s_before = s_phase;
        s_phase = PH_PRESSED; s_pressed = BTN_BACK;
      end
      CMD_REMOTE: begin
        if (s_phase == PH_IDLE) begin
          s_target = it.request_dose_cg;
          s_corr = s_target - ((s_target > 150) ? 150 : 0);
          s_prevbtn = BTN_RIGHT; s_press_t = t; s_phase = PH_CONFIRM;
        end
      end
      default: begin
        case (s_phase)
          PH_FILTER: begin
            if (t - s_filter_t > 32'd20) s_phase = PH_PRESSED;
            else if (!it.button_still_low) s_phase = PH_IDLE;
          end
          PH_PRESSED: begin
            if (s_before == PH_DEBUG)
              s_phase = (s_pressed == BTN_LEFT || s_pressed == BTN_RIGHT) ? PH_DEBUG : PH_IDLE;
            else if (s_before == PH_IDLE) begin
              s_prevbtn = s_pressed; s_press_t = t;
              if (s_pressed == BTN_LEFT) begin
                s_target = c_single; s_corr = int'(c_single) - int'(c_smargin);
                s_phase = PH_CONFIRM;
              end else if (s_pressed == BTN_RIGHT) begin
                s_target = c_double; s_corr = int'(c_double) - int'(c_dmargin);
                s_phase = PH_CONFIRM;
              end else if (s_pressed == BTN_BACK) s_phase = PH_DEBUG;
              else s_phase = PH_IDLE;
            end else s_phase = s_before;
          end
          PH_CONFIRM: if (t - s_press_t > 32'd2000) s_phase = PH_IDLE;
          PH_TARE: if (it.tare_ok) s_phase = PH_CONFIGURED;
          PH_CONFIGURED: begin
            s_won = w; s_on_t = t; s_motor = 1; s_start = t;
            s_prevw = w; s_prevw_t = t; s_sum = 0; s_count = 0; s_phase = PH_RUN;
          end
          PH_RUN: begin
            if (t - s_start > 32'd30000) s_phase = PH_STOP;
            else if (w >= 100 && w - s_prevw >= 20) begin
              g = w - s_prevw;
              if (s_prevw > s_corr) s_phase = PH_TOPUP;
              else begin
                dt = t - s_prevw_t;
                num = 1000 * longint'(g);
                rq = (dt == 0) ? 65535 : num / longint'(dt);
                if (rq > 65535) rq = 65535;
                s_prevw = w; s_prevw_t = t;
                if (num > 10 * longint'(dt) && s_count < 65535) begin
                  s_sum = s_sum + 32'(rq); s_count++;
                end
              end
            end
          end
          PH_TOPUP: begin
            if (!s_motor) begin
              if ((t - s_topend >= 32'(c_settle)) ||
                  (w - s_won >= int'(c_mingain) && it.weight_stable)) begin
                rep = 1;
                avg = (s_count > 0) ? s_sum / s_count : 32'd10;
                if (w >= s_target - 8 || avg == 0) s_phase = PH_STOP;
                else begin
                  ms = 1000 * longint'(s_target - w) / longint'(avg);
                  if (ms < 500) ms = 500;
                  if (ms > 1300) ms = 1300;
                  s_stop_t = t + 32'(ms);
                  s_won = w; s_on_t = t; s_motor = 1;
                end
              end
            end else if (t > s_stop_t) begin
              s_runlen = t - s_on_t; s_motor = 0; s_topend = t;
            end
          end
          PH_STOP: begin
            if (s_motor) begin
              s_runlen = t - s_on_t; s_motor = 0; s_settle_t = t;
            end else if (it.weight_stable || t - s_settle_t >= 32'd1500) begin
              s_fstamp = t; s_fweight = w; s_fdur = t - s_start;
              s_phase = PH_FINAL; done = 1;
            end
          end
          PH_FINAL: if (t - s_fstamp > 32'd8000) s_phase = PH_IDLE;
          default: ;
        endcase
      end
    endcase
    r.phase = s_phase;
    r.relay_on = s_motor;
    r.shown_weight_cg = (s_phase == PH_IDLE && w > -30 && w < 30) ? 16'sd0 : 16'(w);
    if (s_phase == PH_FINAL) r.shown_weight_cg = 16'(s_fweight);
    r.target_cg = 15'(s_target);
    r.elapsed_ms = t - s_start;
    r.topup_report = rep;
    r.last_run_ms = s_runlen;
    g = w - s_won;
    r.topup_gain_cg = (g > 32767) ? 16'sh7fff : (g < -32768) ? 16'sh8000 : 16'(g);
    r.final_weight_cg = 16'(s_fweight);
    r.final_time_ms = s_fdur;
    r.session_done = done;
    return r;
  endfunction

  task automatic raw_word(in_item_t it);
    clock_ms = it.now_ms;
    while ($urandom_range(99) < idle_pct) @(posedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    status_q.push_back(dose_step(it));
    n_items++;
    in_valid_i <= 1'b0;
    // the block stays busy after an accept until the word is committed
    @(posedge clk_i);
  endtask

  task automatic send_word(logic [1:0] cmd, int adv, int w, logic st = 1'b1,
                           logic tare = 1'b1, logic low = 1'b1, logic side = 1'b0,
                           logic [14:0] req = '0);
    in_item_t it;
    clock_ms = clock_ms + 32'(adv);
    it.cmd = cmd; it.button_side = side; it.now_ms = clock_ms;
    it.weight_cg = 16'(w); it.weight_stable = st; it.tare_ok = tare;
    it.button_still_low = low; it.request_dose_cg = req;
    raw_word(it);
  endtask

  task automatic drain();
    while (status_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    drain();
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_SINGLE_DOSE:   c_single = val[14:0];
      REG_DOUBLE_DOSE:   c_double = val[14:0];
      REG_SINGLE_MARGIN: c_smargin = val[14:0];
      REG_DOUBLE_MARGIN: c_dmargin = val[14:0];
      REG_MIN_GAIN:      c_mingain = val[14:0];
      REG_SETTLE:        c_settle = val;
      default: ;
    endcase
  endtask

  // well-formed dose session: press, filter, confirm, tare, grind, top-up, settle
  task automatic grind_session(logic side, int step_ms, int flow);
    int w, k;
    w = $urandom_range(40);
    send_word(CMD_BUTTON, 200, w, 1, 0, 1, side);
    send_word(CMD_TICK, 25, w);
    send_word(CMD_TICK, 1, w);
    send_word(CMD_BUTTON, 200, w, 1, 0, 1, side);
    send_word(CMD_TICK, 5, w, 1, 0);
    send_word(CMD_TICK, 5, w, 1, 1);
    send_word(CMD_TICK, 5, w);
    k = 0;
    while (k < 300 && s_phase != PH_IDLE && s_phase != PH_DEBUG) begin
      w = w + (s_motor ? $urandom_range(flow) : $urandom_range(2));
      if (w > 32000) w = 32000;
      // top-up pulses need time to pass to end
      send_word(CMD_TICK, (s_phase == PH_FINAL) ? 2000 :
                          (s_phase == PH_TOPUP) ? $urandom_range(20, 120) :
                          $urandom_range(step_ms),
                w, $urandom_range(3) != 0);
      k++;
    end
  endtask

  task automatic test_directed();
    in_item_t it;
    send_word(CMD_TICK, 1, 29);
    send_word(CMD_TICK, 1, -29);
    send_word(CMD_TICK, 1, 32767);
    send_word(CMD_TICK, 1, -32768);
    send_word(CMD_BACK, 200, 0);
    send_word(CMD_TICK, 1, 0);             // enters debug
    send_word(CMD_BUTTON, 10, 0);          // edge inside the debounce window
    send_word(CMD_REMOTE, 1, 0, 1, 1, 1, 0, 15'd500); // ignored off idle
    send_word(CMD_BACK, 1, 0);
    send_word(CMD_TICK, 1, 0);
    send_word(CMD_REMOTE, 1, 0, 1, 1, 1, 0, 15'd150); // no correction
    send_word(CMD_TICK, 2500, 0);          // confirm timeout
    send_word(CMD_REMOTE, 1, 0, 1, 1, 1, 0, 15'h7fff);
    send_word(CMD_BUTTON, 200, 0, 1, 1, 1, 0); // mismatched side cancels
    send_word(CMD_BUTTON, 200, 0, 1, 1, 0, 1);
    send_word(CMD_TICK, 2, 0, 1, 1, 0);    // released during filter
    // time wrap on the clock
    it = '0; it.cmd = CMD_TICK; it.now_ms = 32'hffff_fff0; it.weight_cg = 16'sd5;
    raw_word(it);
    clock_ms = 32'hffff_fff0;
    grind_session(1'b0, 50, 40);
    grind_session(1'b1, 0, 60);            // zero time steps in run
  endtask

  task automatic test_config_sweep();
    write_reg(REG_SINGLE_DOSE, 16'd0);
    write_reg(REG_SINGLE_MARGIN, 16'h7fff); // corrected target negative
    write_reg(REG_MIN_GAIN, 16'd0);
    write_reg(REG_SETTLE, 16'd0);
    grind_session(1'b0, 30, 30);
    write_reg(REG_DOUBLE_DOSE, 16'h7fff);
    write_reg(REG_DOUBLE_MARGIN, 16'd0);
    write_reg(REG_MIN_GAIN, 16'h7fff);
    write_reg(REG_SETTLE, 16'hffff);
    grind_session(1'b1, 400, 300);         // target out of reach, run times out
    write_reg(REG_SINGLE_DOSE, 16'd700);
    write_reg(REG_SINGLE_MARGIN, 16'd80);
    write_reg(REG_DOUBLE_DOSE, 16'd1600);
    write_reg(REG_DOUBLE_MARGIN, 16'd120);
    write_reg(REG_MIN_GAIN, 16'd12);
    write_reg(REG_SETTLE, 16'd600);
  endtask

  task automatic test_random_stream();
    in_item_t it;
    while (n_items < 800) begin
      if ($urandom_range(9) < 7) grind_session(1'($urandom_range(1)), $urandom_range(20, 120),
                                               $urandom_range(10, 80));
      else repeat (8) begin
        it.cmd = 2'($urandom_range(3)); it.button_side = 1'($urandom_range(1));
        it.now_ms = ($urandom_range(19) == 0) ? $urandom() : clock_ms + $urandom_range(400);
        it.weight_cg = 16'($urandom()); it.weight_stable = 1'($urandom_range(1));
        it.tare_ok = 1'($urandom_range(1)); it.button_still_low = 1'($urandom_range(1));
        it.request_dose_cg = 15'($urandom());
        raw_word(it);
      end
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    out_item_t e;
    if (out_valid_o && out_ready_i) begin
      n_words++;
      if (status_q.size() == 0) begin
        $error("status word with nothing expected");
        errors++;
      end else begin
        e = status_q.pop_front();
        if (out_data_o.phase !== e.phase) begin
          $error("phase exp %0d got %0d", e.phase, out_data_o.phase); errors++; end
        if (out_data_o.relay_on !== e.relay_on) begin
          $error("relay_on exp %0d got %0d", e.relay_on, out_data_o.relay_on); errors++; end
        if (out_data_o.shown_weight_cg !== e.shown_weight_cg) begin
          $error("shown_weight_cg exp %0d got %0d", e.shown_weight_cg,
                 out_data_o.shown_weight_cg); errors++; end
        if (out_data_o.target_cg !== e.target_cg) begin
          $error("target_cg exp %0d got %0d", e.target_cg, out_data_o.target_cg); errors++; end
        if (out_data_o.elapsed_ms !== e.elapsed_ms) begin
          $error("elapsed_ms exp %0d got %0d", e.elapsed_ms, out_data_o.elapsed_ms); errors++; end
        if (out_data_o.topup_report !== e.topup_report) begin
          $error("topup_report exp %0d got %0d", e.topup_report, out_data_o.topup_report);
          errors++; end
        if (out_data_o.last_run_ms !== e.last_run_ms) begin
          $error("last_run_ms exp %0d got %0d", e.last_run_ms, out_data_o.last_run_ms);
          errors++; end
        if (out_data_o.topup_gain_cg !== e.topup_gain_cg) begin
          $error("topup_gain_cg exp %0d got %0d", e.topup_gain_cg, out_data_o.topup_gain_cg);
          errors++; end
        if (out_data_o.final_weight_cg !== e.final_weight_cg) begin
          $error("final_weight_cg exp %0d got %0d", e.final_weight_cg,
                 out_data_o.final_weight_cg); errors++; end
        if (out_data_o.final_time_ms !== e.final_time_ms) begin
          $error("final_time_ms exp %0d got %0d", e.final_time_ms, out_data_o.final_time_ms);
          errors++; end
        if (out_data_o.session_done !== e.session_done) begin
          $error("session_done exp %0d got %0d", e.session_done, out_data_o.session_done);
          errors++; end
      end
    end
  end

  // receiver stall pattern
  always @(posedge clk_i) begin
    if (quiet_out) out_ready_i <= 1'b1;
    else out_ready_i <= ($urandom_range(99) >= 9);
  end

  // watchdog on accept activity
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) watchdog <= 0;
    else watchdog <= watchdog + 1;
    if (watchdog > 5000) begin
      $display("grind_by_weight_dosing_controller: mismatch");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0; in_valid_i = 1'b0; in_data_i = '0; out_ready_i = 1'b0;
    cfg_we_i = 1'b0; cfg_idx_i = '0; cfg_data_i = '0;
    errors = 0; n_items = 0; n_words = 0; watchdog = 0; clock_ms = 32'd1000;
    idle_pct = 9; quiet_out = 1'b0;
    reset_model();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_config_sweep();
    idle_pct = 0; quiet_out = 1'b1;        // stretch without idling
    grind_session(1'b1, 60, 50);
    idle_pct = 9; quiet_out = 1'b0;
    test_random_stream();
    drain();
    $display("%0d event words sent, %0d status words checked", n_items, n_words);
    $display("covered sessions, debug/back paths, remote requests, register extremes");
    if (errors == 0) $display("grind_by_weight_dosing_controller: match");
    else $display("grind_by_weight_dosing_controller: mismatch");
    $finish;
  end

endmodule

/* filelist.f */
design/gbw_pkg.sv
design/gbw_div.sv
design/gbw_ctrl.sv
design/gbw_dp.sv
design/grind_by_weight_dosing_controller.sv
sim/tb.sv
